// ===== sv/cha_pkg.sv =====
package cha_pkg;

  localparam int MEM_BYTES_DEF  = 4096;
  localparam int DESC_BYTES_DEF = 8;

  localparam int CMD_W  = 3;
  localparam int SIZE_W = 13;
  localparam int SLOT_W = 9;
  localparam int OFF_W  = 12;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;
  localparam int USED_W = 9;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REALLOC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SIZE    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_OOM = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD = 2'd2;
  localparam logic [ST_W-1:0] ST_OFF = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_IDLE, OP_LOOK, OP_DECODE, OP_SCAN_RD, OP_SCAN_CHK, OP_GRANT,
    OP_CP_RD, OP_CP_WR, OP_FREE_SETUP, OP_MV_RD, OP_MV_WR, OP_RB_RD, OP_RB_WR,
    OP_FIX, OP_ZERO, OP_TR_RD, OP_TR_CHK, OP_ACC_RD, OP_ACC_WR, OP_ACC_CAP,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic            take;
    logic            grow;
    logic            bsz_load;
    logic            set_st;
    logic [ST_W-1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             h_zero;
    logic             live;
    logic             off_bad;
    logic             size_zero;
    logic             no_room;
    logic             scan_end;
    logic             slot_used;
    logic             table_full;
    logic             cnt_zero;
    logic             cnt_last;
    logic             h_is_lowest;
    logic             lowest_zero;
    logic             out_busy;
  } dp_flag_t;

endpackage

// ===== sv/cha_if.sv =====
interface cha_req_if;
  import cha_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] req_size;
  logic [SLOT_W-1:0] handle_in;
  logic [OFF_W-1:0]  byte_offset;
  logic [BYTE_W-1:0] write_byte;
  modport source (output valid, command, req_size, handle_in, byte_offset, write_byte,
                  input ready);
  modport sink (input valid, command, req_size, handle_in, byte_offset, write_byte,
                output ready);
endinterface

interface cha_rsp_if;
  import cha_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] handle_out;
  logic [BYTE_W-1:0] read_byte;
  logic [SIZE_W-1:0] block_size;
  logic [SIZE_W-1:0] free_bytes;
  logic [USED_W-1:0] used_count;
  modport source (output valid, status, handle_out, read_byte, block_size, free_bytes,
                  used_count, input ready);
  modport sink (input valid, status, handle_out, read_byte, block_size, free_bytes,
                used_count, output ready);
endinterface

// ===== sv/cha_ctrl.sv =====
module cha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cha_pkg::dp_flag_t flag,
  output cha_pkg::dp_cmd_t  cmd
);
  import cha_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_GRANT_REUSE, S_GRANT_NEW,
    S_CP_RD, S_CP_WR, S_FREE_SETUP, S_MV_RD, S_MV_WR, S_RB_RD, S_RB_WR, S_FIX,
    S_ZERO, S_TR_RD, S_TR_CHK, S_ACC_RD, S_ACC_WR, S_ACC_CAP, S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_NONE;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        // The byte store is zeroed once after reset before any request is taken.
        cmd.op = OP_ZERO;
        if (flag.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.op    = OP_IDLE;
        cmd.take  = req_valid;
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.op     = OP_LOOK;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.op     = OP_DECODE;
        state_next = S_DONE;
        case (flag.cmd)
          CMD_ALLOC: begin
            if (flag.size_zero) begin
              state_next = S_DONE;
            end else if (flag.no_room) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_OOM;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          CMD_FREE: begin
            if (flag.h_zero) begin
              state_next = S_DONE;
            end else if (!flag.live) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end else begin
              cmd.bsz_load = 1'b1;
              state_next   = S_FREE_SETUP;
            end
          end
          CMD_REALLOC: begin
            if (!flag.h_zero && !flag.live) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end else if (flag.size_zero) begin
              if (!flag.h_zero) state_next = S_FREE_SETUP;
            end else if (flag.no_room) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_OOM;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          CMD_READ, CMD_WRITE: begin
            if (flag.h_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_OFF;
            end else if (!flag.live) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_BAD;
            end else begin
              cmd.bsz_load = 1'b1;
              if (flag.off_bad) begin
                cmd.set_st = 1'b1;
                cmd.st     = ST_OFF;
              end else if (flag.cmd == CMD_READ) begin
                state_next = S_ACC_RD;
              end else begin
                state_next = S_ACC_WR;
              end
            end
          end
          CMD_SIZE: begin
            if (!flag.h_zero) begin
              if (!flag.live) begin
                cmd.set_st = 1'b1;
                cmd.st     = ST_BAD;
              end else begin
                cmd.bsz_load = 1'b1;
              end
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        cmd.op = OP_SCAN_RD;
        if (flag.scan_end) begin
          if (flag.table_full) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_OOM;
            state_next = S_DONE;
          end else begin
            state_next = S_GRANT_NEW;
          end
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.op     = OP_SCAN_CHK;
        state_next = flag.slot_used ? S_SCAN_RD : S_GRANT_REUSE;
      end
      S_GRANT_REUSE, S_GRANT_NEW: begin
        cmd.op   = OP_GRANT;
        cmd.grow = (state == S_GRANT_NEW);
        if (flag.cmd == CMD_REALLOC && !flag.h_zero) begin
          state_next = S_CP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CP_RD: begin
        cmd.op     = OP_CP_RD;
        state_next = flag.cnt_zero ? S_FREE_SETUP : S_CP_WR;
      end
      S_CP_WR: begin
        cmd.op     = OP_CP_WR;
        state_next = flag.cnt_last ? S_FREE_SETUP : S_CP_RD;
      end
      S_FREE_SETUP: begin
        cmd.op     = OP_FREE_SETUP;
        state_next = S_MV_RD;
      end
      S_MV_RD: begin
        cmd.op     = OP_MV_RD;
        state_next = flag.cnt_zero ? S_RB_RD : S_MV_WR;
      end
      S_MV_WR: begin
        cmd.op     = OP_MV_WR;
        state_next = flag.cnt_last ? S_RB_RD : S_MV_RD;
      end
      S_RB_RD: begin
        cmd.op     = OP_RB_RD;
        state_next = flag.scan_end ? S_FIX : S_RB_WR;
      end
      S_RB_WR: begin
        cmd.op     = OP_RB_WR;
        state_next = S_RB_RD;
      end
      S_FIX: begin
        cmd.op     = OP_FIX;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.op = OP_ZERO;
        if (flag.cnt_last) state_next = flag.h_is_lowest ? S_TR_RD : S_DONE;
      end
      S_TR_RD: begin
        cmd.op     = OP_TR_RD;
        state_next = flag.lowest_zero ? S_DONE : S_TR_CHK;
      end
      S_TR_CHK: begin
        cmd.op     = OP_TR_CHK;
        state_next = flag.slot_used ? S_DONE : S_TR_RD;
      end
      S_ACC_RD: begin
        cmd.op     = OP_ACC_RD;
        state_next = S_ACC_CAP;
      end
      S_ACC_CAP: begin
        cmd.op     = OP_ACC_CAP;
        state_next = S_DONE;
      end
      S_ACC_WR: begin
        cmd.op     = OP_ACC_WR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!flag.out_busy) begin
          cmd.op     = OP_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/cha_datapath.sv =====
module cha_datapath #(
  parameter int MEM_BYTES  = cha_pkg::MEM_BYTES_DEF,
  parameter int DESC_BYTES = cha_pkg::DESC_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cha_pkg::dp_cmd_t            cmd,
  output cha_pkg::dp_flag_t           flag,
  input  logic [cha_pkg::CMD_W-1:0]   command,
  input  logic [cha_pkg::SIZE_W-1:0]  req_size,
  input  logic [cha_pkg::SLOT_W-1:0]  handle_in,
  input  logic [cha_pkg::OFF_W-1:0]   byte_offset,
  input  logic [cha_pkg::BYTE_W-1:0]  write_byte,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [cha_pkg::ST_W-1:0]    status,
  output logic [cha_pkg::SLOT_W-1:0]  handle_out,
  output logic [cha_pkg::BYTE_W-1:0]  read_byte,
  output logic [cha_pkg::SIZE_W-1:0]  block_size,
  output logic [cha_pkg::SIZE_W-1:0]  free_bytes,
  output logic [cha_pkg::USED_W-1:0]  used_count
);
  import cha_pkg::*;

  localparam int AW    = $clog2(MEM_BYTES);
  localparam int LW    = AW + 1;
  localparam int WW    = ((LW > SIZE_W) ? LW : SIZE_W) + 2;
  localparam int SLOTS = 1 << SLOT_W;

  // Byte store and descriptor table.
  logic [BYTE_W-1:0] byte_mem [MEM_BYTES];
  logic              slot_use [SLOTS];
  logic [AW-1:0]     slot_bas [SLOTS];
  logic [LW-1:0]     slot_len [SLOTS];

  // Latched request.
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [SLOT_W-1:0] h_r;
  logic [OFF_W-1:0]  off_r;
  logic [BYTE_W-1:0] wb_r;

  // Allocator state.
  logic [AW-1:0]     free_base;
  logic [LW-1:0]     free_len;
  logic [SLOT_W-1:0] lowest;
  logic [USED_W-1:0] live_cnt;

  // Working registers.
  logic [AW-1:0]     ob;
  logic [LW-1:0]     ol;
  logic [SLOT_W:0]   k;
  logic [AW-1:0]     src, dst;
  logic [LW-1:0]     cnt;
  logic [ST_W-1:0]   st_r;
  logic [SLOT_W-1:0] hout_r;
  logic [BYTE_W-1:0] rb_r;
  logic [LW-1:0]     bsz_r;

  // Memory ports.
  logic [AW-1:0]     b_raddr, b_waddr;
  logic              b_we;
  logic [BYTE_W-1:0] b_wdata, b_q, b_data;
  logic [SLOT_W-1:0] s_raddr, s_waddr;
  logic              s_we, s_wuse;
  logic [AW-1:0]     s_wbas;
  logic [LW-1:0]     s_wlen;
  logic              qu;
  logic [AW-1:0]     qb;
  logic [LW-1:0]     ql;

  logic [WW-1:0]     sz;
  logic [LW-1:0]     ncopy;
  logic [AW-1:0]     fb_new;

  assign sz     = (WW'(size_r) + WW'(3)) & ~WW'(3);
  assign ncopy  = (WW'(size_r) < WW'(ol)) ? LW'(size_r) : ol;
  assign fb_new = free_base + AW'(sz);
  assign b_data = b_q;

  always_comb begin
    b_raddr = src;
    b_waddr = dst;
    b_we    = 1'b0;
    b_wdata = b_data;
    case (cmd.op)
      OP_ACC_RD: b_raddr = ob + AW'(off_r);
      OP_ACC_WR: begin
        b_we    = 1'b1;
        b_waddr = ob + AW'(off_r);
        b_wdata = wb_r;
      end
      OP_CP_WR, OP_MV_WR: b_we = 1'b1;
      OP_ZERO: begin
        b_we    = 1'b1;
        b_wdata = '0;
      end
      default: b_we = 1'b0;
    endcase
  end

  always_comb begin
    s_raddr = h_r;
    s_waddr = k[SLOT_W-1:0];
    s_we    = 1'b0;
    s_wuse  = 1'b1;
    s_wbas  = free_base;
    s_wlen  = LW'(sz);
    case (cmd.op)
      OP_SCAN_RD, OP_RB_RD: s_raddr = k[SLOT_W-1:0];
      OP_TR_RD:             s_raddr = lowest;
      OP_GRANT:             s_we = 1'b1;
      OP_RB_WR: begin
        // Blocks above the released one slide down by its length.
        s_we   = qu && (qb > ob);
        s_wbas = qb - AW'(ol);
        s_wlen = ql;
      end
      OP_FIX: begin
        s_we    = 1'b1;
        s_waddr = h_r;
        s_wuse  = 1'b0;
        s_wbas  = '0;
        s_wlen  = '0;
      end
      default: s_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) byte_mem[b_waddr] <= b_wdata;
    b_q <= byte_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      slot_use[s_waddr] <= s_wuse;
      slot_bas[s_waddr] <= s_wbas;
      slot_len[s_waddr] <= s_wlen;
    end
    qu <= slot_use[s_raddr];
    qb <= slot_bas[s_raddr];
    ql <= slot_len[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_base <= '0;
      free_len  <= LW'(MEM_BYTES - DESC_BYTES);
      lowest    <= '0;
      live_cnt  <= '0;
      rsp_valid <= 1'b0;
      // The clearing pass after reset walks the whole store from address zero.
      dst       <= '0;
      cnt       <= LW'(MEM_BYTES);
    end else begin
      if (rsp_valid && rsp_ready && cmd.op != OP_DONE) rsp_valid <= 1'b0;
      if (cmd.set_st) st_r <= cmd.st;
      case (cmd.op)
        OP_IDLE: begin
          if (cmd.take) begin
            cmd_r  <= command;
            size_r <= req_size;
            h_r    <= handle_in;
            off_r  <= byte_offset;
            wb_r   <= write_byte;
            st_r   <= ST_OK;
            hout_r <= '0;
            rb_r   <= '0;
            bsz_r  <= '0;
          end
        end
        OP_DECODE: begin
          ob <= qb;
          ol <= ql;
          k  <= (SLOT_W+1)'(1);
          if (cmd.bsz_load) bsz_r <= ql;
        end
        OP_SCAN_CHK: if (qu) k <= k + 1'b1;
        OP_GRANT: begin
          if (cmd.grow) begin
            lowest   <= lowest + 1'b1;
            free_len <= free_len - LW'(sz) - LW'(DESC_BYTES);
          end else begin
            free_len <= free_len - LW'(sz);
          end
          free_base <= fb_new;
          live_cnt  <= live_cnt + 1'b1;
          hout_r    <= k[SLOT_W-1:0];
          bsz_r     <= LW'(sz);
          src       <= ob;
          dst       <= free_base;
          cnt       <= ncopy;
        end
        OP_CP_WR, OP_MV_WR, OP_ZERO: begin
          src <= src + 1'b1;
          dst <= dst + 1'b1;
          cnt <= cnt - 1'b1;
        end
        OP_FREE_SETUP: begin
          src <= ob + AW'(ol);
          dst <= ob;
          cnt <= LW'(free_base) - LW'(ob) - ol;
          k   <= (SLOT_W+1)'(1);
        end
        OP_RB_WR: k <= k + 1'b1;
        OP_FIX: begin
          free_base <= free_base - AW'(ol);
          free_len  <= free_len + ol;
          dst       <= free_base - AW'(ol);
          cnt       <= ol;
          live_cnt  <= live_cnt - 1'b1;
        end
        OP_TR_CHK: begin
          if (!qu) begin
            free_len <= free_len + LW'(DESC_BYTES);
            lowest   <= lowest - 1'b1;
          end
        end
        OP_ACC_CAP: rb_r <= b_data;
        OP_DONE: begin
          rsp_valid  <= 1'b1;
          status     <= st_r;
          handle_out <= hout_r;
          read_byte  <= rb_r;
          block_size <= SIZE_W'(bsz_r);
          free_bytes <= SIZE_W'(free_len);
          used_count <= live_cnt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    flag             = '0;
    flag.cmd         = cmd_r;
    flag.h_zero      = (h_r == '0);
    flag.live        = (h_r != '0) && (h_r <= lowest) && qu;
    flag.off_bad     = (WW'(off_r) >= WW'(ql));
    flag.size_zero   = (size_r == '0);
    flag.no_room     = (WW'(free_len) < sz + WW'(2 * DESC_BYTES));
    flag.scan_end    = (k > {1'b0, lowest});
    flag.slot_used   = qu;
    flag.table_full  = (lowest == '1);
    flag.cnt_zero    = (cnt == '0);
    flag.cnt_last    = (cnt == LW'(1));
    flag.h_is_lowest = (h_r == lowest);
    flag.lowest_zero = (lowest == '0);
    flag.out_busy    = rsp_valid && !rsp_ready;
  end

endmodule

// ===== sv/compacting_handle_allocator_unit.sv =====
// Handle-based compacting allocator over a private byte store.
// Requests arrive on the req channel (valid/ready): command, req_size, handle_in,
// byte_offset and write_byte. Each request yields exactly one response on the
// rsp channel with status, handle_out, read_byte, block_size, free_bytes and
// used_count, where the last two report the allocator after the request.
// One request is worked on at a time; ready is high only while the sequencer is
// idle. An alloc checks descriptor slots in turn, reusing the first free slot it
// finds or, past the last one, growing the table. A free slides every later byte
// down over the single byte-store port pair, reading and then writing each byte,
// revisits every slot, zeroes the released bytes at one per cycle and trims empty
// top slots; realloc adds a byte-by-byte copy of the old block.
// Synchronous reset empties the table and frees all but DESC_BYTES of the store
// at once, then the block zeroes all MEM_BYTES bytes of the byte store (4096 by
// default) at one byte per cycle with ready low before it takes its first request.
// The response sits in an output register; if the receiver stalls, the block
// holds the response and finishes its next request only when the register frees.
module compacting_handle_allocator_unit #(
  parameter int MEM_BYTES  = cha_pkg::MEM_BYTES_DEF,
  parameter int DESC_BYTES = cha_pkg::DESC_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  cha_req_if.sink   req,
  cha_rsp_if.source rsp
);
  import cha_pkg::*;

  dp_cmd_t  cmd;
  dp_flag_t flag;

  cha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .flag      (flag),
    .cmd       (cmd)
  );

  cha_datapath #(
    .MEM_BYTES  (MEM_BYTES),
    .DESC_BYTES (DESC_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flag        (flag),
    .command     (req.command),
    .req_size    (req.req_size),
    .handle_in   (req.handle_in),
    .byte_offset (req.byte_offset),
    .write_byte  (req.write_byte),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .handle_out  (rsp.handle_out),
    .read_byte   (rsp.read_byte),
    .block_size  (rsp.block_size),
    .free_bytes  (rsp.free_bytes),
    .used_count  (rsp.used_count)
  );

  // Only one request is in flight.
  a_single: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  // A failed allocation hands out nothing.
  a_oom: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OOM |-> rsp.handle_out == '0 && rsp.block_size == '0)
    else $error("out-of-memory response carries a handle or size");

  // A handed-out handle always comes with success and a nonzero block.
  a_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.handle_out != '0 |-> rsp.status == ST_OK && rsp.block_size != '0)
    else $error("handle returned without a successful allocation");

endmodule
